// ----- rtl/slme_pkg.sv -----
// slme_pkg: shared types and constants of the spherical lobe mixture evaluator
// no dependencies
package slme_pkg;

  localparam int DIR_W = 16;
  localparam int COL_W = 16;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic CFG_NUM_LOBES = 1'b0;
  localparam logic CFG_SHARPNESS = 1'b1;

  localparam logic [8:0] NUM_LOBES_RST = 9'd48;
  localparam logic [6:0] SHARPNESS_RST = 7'd18;

  // q1.30 one and the exponent cut-off 12.0 in q.28
  localparam logic [31:0] Q30_ONE    = 32'h4000_0000;
  localparam logic [43:0] EXP_CUTOFF = 44'(12) << 28;

  typedef struct packed {
    logic              req_type;
    logic [7:0]        lobe_index;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [15:0]       color_r;
    logic [15:0]       color_g;
    logic [15:0]       color_b;
  } in_req_t;

  typedef struct packed {
    logic [15:0] out_r;
    logic [15:0] out_g;
    logic [15:0] out_b;
  } out_res_t;

  // handshake between sequencer and exp unit
  typedef struct packed {
    logic        start;
    logic [43:0] n;
  } exp_cmd_t;

  typedef struct packed {
    logic        done;
    logic [15:0] weight;
  } exp_rsp_t;

endpackage

// ----- rtl/spherical_lobe_mixture_eval_top.sv -----
// spherical lobe mixture evaluator, top level
// a load is taken while idle; a query offers its result after a first pass over the lobes
// finds the maximum dot, a second pass weights each lobe through the iterative exp unit
// (which skips the iteration when the weight is cut off), then three divisions
// one request at a time; rst is synchronous and restores the register defaults
// depends on slme_pkg, slme_exp, slme_div
module spherical_lobe_mixture_eval_top
  import slme_pkg::*;
#(
  parameter int MAX_LOBES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_req_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_res_t    out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int AW = $clog2(MAX_LOBES);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_DOT   = 4'd2;
  localparam logic [3:0] S_MAXU  = 4'd3;
  localparam logic [3:0] S_EXPW  = 4'd4;
  localparam logic [3:0] S_ACC   = 4'd5;
  localparam logic [3:0] S_DIVS  = 4'd6;
  localparam logic [3:0] S_DIVW  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;
  localparam logic [3:0] S_MUL   = 4'd9;

  logic [8:0] num_lobes;
  logic [6:0] sharpness;

  logic [47:0] dir_mem [MAX_LOBES];
  logic [47:0] col_mem [MAX_LOBES];
  logic [47:0] dir_rd;
  logic [47:0] col_rd;

  logic [3:0]  state;
  logic        pass2;
  logic [AW:0] idx;
  logic [AW:0] count;
  logic [1:0]  comp;
  logic [1:0]  ch;
  logic signed [15:0] qx, qy, qz;
  logic signed [35:0] dot;
  logic signed [35:0] maxd;
  logic [43:0] nval;
  logic [24:0] wsum;
  logic [47:0] acc_r, acc_g, acc_b;
  logic [15:0] wlat;
  logic [15:0] res_r, res_g, res_b;
  logic [AW:0] cnt_clip;

  exp_cmd_t ecmd;
  exp_rsp_t ersp;
  logic        dstart, ddone;
  logic [47:0] ddvd, dq;

  logic signed [15:0] ma, mb;
  logic signed [31:0] mp;

  always_comb begin
    case (comp)
      2'd0:    begin ma = qx; mb = $signed(dir_rd[47:32]); end
      2'd1:    begin ma = qy; mb = $signed(dir_rd[31:16]); end
      default: begin ma = qz; mb = $signed(dir_rd[15:0]);  end
    endcase
  end
  assign mp = ma * mb;

  assign cnt_clip = (32'(num_lobes) > MAX_LOBES) ? (AW+1)'(MAX_LOBES) : (AW+1)'(num_lobes);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_lobes <= NUM_LOBES_RST;
      sharpness <= SHARPNESS_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_NUM_LOBES) num_lobes <= cfg_data;
      else sharpness <= cfg_data[6:0];
    end
  end

  // table memories
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && in_data.req_type == REQ_LOAD
        && 32'(in_data.lobe_index) < MAX_LOBES) begin
      dir_mem[AW'(in_data.lobe_index)] <= {in_data.dir_x, in_data.dir_y, in_data.dir_z};
      col_mem[AW'(in_data.lobe_index)] <= {in_data.color_r, in_data.color_g,
                                           in_data.color_b};
    end
    dir_rd <= dir_mem[idx[AW-1:0]];
    col_rd <= col_mem[idx[AW-1:0]];
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data  = '{out_r: res_r, out_g: res_g, out_b: res_b};

  assign ecmd.start = (state == S_MAXU) && pass2;
  assign ecmd.n     = nval;

  always_comb begin
    case (ch)
      2'd0:    ddvd = acc_r;
      2'd1:    ddvd = acc_g;
      default: ddvd = acc_b;
    endcase
  end
  assign dstart = (state == S_DIVS);

  slme_exp u_exp (.clk(clk), .rst(rst), .cmd(ecmd), .rsp(ersp));
  slme_div u_div (.clk(clk), .rst(rst), .start(dstart), .dividend(ddvd),
                  .divisor(wsum == '0 ? 25'd65536 : wsum), .done(ddone), .quotient(dq));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          idx <= '0;
          if (in_valid && in_data.req_type == REQ_QUERY) begin
            qx    <= in_data.dir_x;
            qy    <= in_data.dir_y;
            qz    <= in_data.dir_z;
            count <= cnt_clip;
            pass2 <= 1'b0;
            maxd  <= '0;
            wsum  <= '0;
            acc_r <= '0;
            acc_g <= '0;
            acc_b <= '0;
            state <= (cnt_clip == '0) ? S_DIVS : S_RD;
            ch    <= '0;
          end
        end
        S_RD: begin
          comp  <= '0;
          dot   <= '0;
          state <= S_DOT;
        end
        S_DOT: begin
          dot  <= dot + 36'(mp);
          comp <= comp + 2'd1;
          if (comp == 2'd2) state <= S_MAXU;
        end
        S_MAXU: begin
          if (!pass2) begin
            if (idx == '0 || dot > maxd) maxd <= dot;
            if (idx == count - 1'b1) begin
              pass2 <= 1'b1;
              idx   <= '0;
            end else begin
              idx <= idx + 1'b1;
            end
            state <= S_RD;
          end else begin
            state <= S_EXPW;
          end
        end
        S_EXPW: begin
          if (ersp.done) begin
            wlat  <= ersp.weight;
            wsum  <= wsum + 25'(ersp.weight);
            comp  <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // one colour product per cycle
          case (comp)
            2'd0:    acc_r <= acc_r + 48'({16'd0, wlat} * {16'd0, col_rd[47:32]});
            2'd1:    acc_g <= acc_g + 48'({16'd0, wlat} * {16'd0, col_rd[31:16]});
            default: acc_b <= acc_b + 48'({16'd0, wlat} * {16'd0, col_rd[15:0]});
          endcase
          comp <= comp + 2'd1;
          if (comp == 2'd2) state <= S_ACC;
        end
        S_ACC: begin
          if (idx == count - 1'b1) begin
            ch    <= '0;
            state <= S_DIVS;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_RD;
          end
        end
        S_DIVS: state <= S_DIVW;
        S_DIVW: begin
          if (ddone) begin
            case (ch)
              2'd0:    res_r <= (dq > 48'd65535) ? 16'hFFFF : dq[15:0];
              2'd1:    res_g <= (dq > 48'd65535) ? 16'hFFFF : dq[15:0];
              default: res_b <= (dq > 48'd65535) ? 16'hFFFF : dq[15:0];
            endcase
            if (ch == 2'd2) state <= S_OUT;
            else begin
              ch    <= ch + 2'd1;
              state <= S_DIVS;
            end
          end
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // exponent argument, sharpness times (max - dot)
  assign nval = 44'(sharpness) * 44'(maxd - dot);

endmodule

// ----- rtl/slme_exp.sv -----
// slme_exp: iterative exp(-n) weight unit, one multiply per cycle
// depends on slme_pkg
module slme_exp
  import slme_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  exp_cmd_t cmd,
  output exp_rsp_t rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HORN = 2'd1;
  localparam logic [1:0] S_DIVK = 2'd2;
  localparam logic [1:0] S_SQR  = 2'd3;

  logic [1:0]  state;
  logic [2:0]  k;
  logic [2:0]  sq;
  logic [32:0] u;
  logic [31:0] acc;
  logic [31:0] prod;
  logic [63:0] mul;
  logic [31:0] quot;
  logic [15:0] weight;
  logic        done;
  logic [17:0] wsh;

  // shared multiplier: horner step or squaring
  assign mul = (state == S_SQR) ? 64'(acc) * 64'(acc) : 64'(u) * 64'(acc);

  // division by the small constant k
  always_comb begin
    case (k)
      3'd1:    quot = prod;
      3'd2:    quot = prod >> 1;
      3'd3:    quot = 32'((64'(prod) * 64'h5555_5556) >> 32);
      3'd4:    quot = prod >> 2;
      3'd5:    quot = 32'((64'(prod) * 64'h3333_3334) >> 32);
      3'd6:    quot = 32'((64'(prod) * 64'h2AAA_AAAB) >> 32);
      default: quot = prod;
    endcase
  end

  assign wsh = 18'(acc >> 14);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd.start) begin
            if (cmd.n >= EXP_CUTOFF) begin
              weight <= '0;
              done   <= 1'b1;
            end else begin
              u     <= 33'(cmd.n >> 3);
              acc   <= Q30_ONE;
              k     <= 3'd6;
              state <= S_HORN;
            end
          end
        end
        S_HORN: begin
          prod  <= 32'(mul >> 30);
          state <= S_DIVK;
        end
        S_DIVK: begin
          acc <= Q30_ONE - quot;
          if (k == 3'd1) begin
            sq    <= '0;
            state <= S_SQR;
          end else begin
            k     <= k - 3'd1;
            state <= S_HORN;
          end
        end
        S_SQR: begin
          if (sq == 3'd5) begin
            weight <= (wsh > 18'd65535) ? 16'hFFFF : wsh[15:0];
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            acc <= 32'(mul >> 30);
            sq  <= sq + 3'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.done   = done;
  assign rsp.weight = weight;

endmodule

// ----- rtl/slme_div.sv -----
// slme_div: restoring divider, one quotient bit per cycle
// depends on slme_pkg
module slme_div
  import slme_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [24:0] divisor,
  output logic        done,
  output logic [47:0] quotient
);

  logic [5:0]  cnt;
  logic        busy;
  logic [25:0] rem;
  logic [25:0] trial;
  logic [24:0] dvs;

  assign trial = {rem[24:0], quotient[47]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        quotient <= dividend;
        dvs      <= divisor;
        rem      <= '0;
        cnt      <= '0;
      end else if (busy) begin
        if (trial[25]) begin
          rem      <= {rem[24:0], quotient[47]};
          quotient <= {quotient[46:0], 1'b0};
        end else begin
          rem      <= trial;
          quotient <= {quotient[46:0], 1'b1};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- test/slme_checker.sv -----
// slme_checker: watches the request and result channels and the register port of the evaluator,
// keeps its own lobe table, predicts each blended colour and compares
// depends on slme_pkg
`timescale 1ns / 1ps
module slme_checker
  import slme_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_stall,
  input  in_req_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  out_res_t out_data,
  input  logic     cfg_we,
  input  logic     cfg_index,
  input  logic [8:0] cfg_data,
  output int       errors,
  output int       pending
);

  localparam int TABLE_DEPTH = 256;

  logic signed [15:0] lobe_dir [TABLE_DEPTH][3];
  logic [15:0]        lobe_col [TABLE_DEPTH][3];
  logic [8:0]         cur_count;
  logic [6:0]         cur_sharp;
  out_res_t           colour_q [$];

  function automatic longint unsigned exp_weight(longint unsigned n);
    longint unsigned u, acc, e;
    if (n >= (64'd12 << 28)) return 0;
    u = n >> 3;
    acc = 64'd1 << 30;
    for (int k = 6; k >= 1; k--) begin
      acc = (64'd1 << 30) - ((u * acc) >> 30) / longint'(k);
    end
    e = acc;
    for (int k = 0; k < 5; k++) begin
      e = (e * e) >> 30;
    end
    e = e >> 14;
    return (e > 65535) ? 65535 : e;
  endfunction

  function automatic longint dot_with(int i, logic signed [15:0] x, logic signed [15:0] y,
                                      logic signed [15:0] z);
    return longint'(x) * longint'(lobe_dir[i][0]) + longint'(y) * longint'(lobe_dir[i][1]) +
           longint'(z) * longint'(lobe_dir[i][2]);
  endfunction

  function automatic out_res_t blend_colour(logic signed [15:0] x, logic signed [15:0] y,
                                            logic signed [15:0] z);
    int n_lobes;
    longint best, d;
    longint unsigned w, wsum, div, v;
    longint unsigned acc [3];
    logic [15:0] res [3];
    out_res_t r;
    n_lobes = (cur_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(cur_count);
    best = 0;
    for (int i = 0; i < n_lobes; i++) begin
      d = dot_with(i, x, y, z);
      if (i == 0 || d > best) best = d;
    end
    wsum = 0;
    for (int c = 0; c < 3; c++) acc[c] = 0;
    for (int i = 0; i < n_lobes; i++) begin
      w = exp_weight(longint'(cur_sharp) * (best - dot_with(i, x, y, z)));
      wsum += w;
      for (int c = 0; c < 3; c++) acc[c] += w * lobe_col[i][c];
    end
    div = (wsum > 0) ? wsum : 65536;
    for (int c = 0; c < 3; c++) begin
      v = acc[c] / div;
      res[c] = (v > 65535) ? 16'hffff : v[15:0];
    end
    r.out_r = res[0];
    r.out_g = res[1];
    r.out_b = res[2];
    return r;
  endfunction

  always @(posedge clk) begin
    out_res_t want;
    if (rst) begin
      cur_count <= NUM_LOBES_RST;
      cur_sharp <= SHARPNESS_RST;
      colour_q.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_NUM_LOBES) cur_count <= cfg_data;
        else cur_sharp <= cfg_data[6:0];
      end
      if (in_valid && !in_stall) begin
        if (in_data.req_type == REQ_LOAD) begin
          lobe_dir[in_data.lobe_index][0] <= in_data.dir_x;
          lobe_dir[in_data.lobe_index][1] <= in_data.dir_y;
          lobe_dir[in_data.lobe_index][2] <= in_data.dir_z;
          lobe_col[in_data.lobe_index][0] <= in_data.color_r;
          lobe_col[in_data.lobe_index][1] <= in_data.color_g;
          lobe_col[in_data.lobe_index][2] <= in_data.color_b;
        end else begin
          colour_q.push_back(blend_colour(in_data.dir_x, in_data.dir_y, in_data.dir_z));
        end
      end
      if (out_valid && !out_stall) begin
        if (colour_q.size() == 0) begin
          if (errors < 10) $display("checker: result %h with no query waiting", out_data);
          errors <= errors + 1;
        end else begin
          want = colour_q.pop_front();
          if (want !== out_data) begin
            if (errors < 10)
              $display("checker: colour mismatch exp r=%h g=%h b=%h got r=%h g=%h b=%h",
                       want.out_r, want.out_g, want.out_b,
                       out_data.out_r, out_data.out_g, out_data.out_b);
            errors <= errors + 1;
          end
        end
      end
      pending <= colour_q.size();
    end
  end

endmodule

// ----- test/tb.sv -----
// tb: stimulus and verdict for the spherical lobe mixture evaluator
// depends on slme_pkg, spherical_lobe_mixture_eval_top and slme_checker
`timescale 1ns / 1ps
module tb;
  import slme_pkg::*;

  localparam int IDLE_LIMIT = 100000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  in_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_res_t out_data;
  logic cfg_we = 0;
  logic cfg_index = CFG_NUM_LOBES;
  logic [8:0] cfg_data = '0;
  int errors, pending;
  int burst_left = 0;
  bit gaps_on = 1;
  bit hold_go = 0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  spherical_lobe_mixture_eval_top u_top (.*);

  slme_checker u_chk (.*);

  // long hold-off is requested by the stimulus and timed here
  always @(posedge clk) begin
    int stall_pct, left;
    if (left == 0) begin
      left = 200;
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 30;
        2: stall_pct = 70;
        default: stall_pct = 95;
      endcase
    end
    left--;
    if (hold_go) begin
      out_stall <= 1;
      repeat (3000) @(posedge clk);
      hold_go = 0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic send_request(in_req_t r);
    in_valid <= 1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        in_valid <= 0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [8:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic load_lobe(logic [7:0] idx, logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] z, logic [15:0] r, logic [15:0] g,
                           logic [15:0] b);
    in_req_t q;
    q = '{REQ_LOAD, idx, x, y, z, r, g, b};
    send_request(q);
  endtask

  task automatic query_dir(logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] z);
    in_req_t q;
    q = '{REQ_QUERY, 8'($urandom), x, y, z, 16'($urandom), 16'($urandom), 16'($urandom)};
    send_request(q);
  endtask

  // mix of magnitudes so weights land between zero and one
  function automatic logic signed [15:0] rand_comp();
    logic signed [15:0] v;
    v = 16'($urandom);
    return v >>> $urandom_range(0, 13);
  endfunction

  initial begin
    logic [8:0] cnt;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    write_reg(CFG_NUM_LOBES, 9'd4);
    load_lobe(8'd0, 16'sd16384, 16'sd0, 16'sd0, 16'hffff, 16'h0000, 16'h0000);
    load_lobe(8'd1, -16'sd32768, -16'sd32768, -16'sd32768, 16'h0000, 16'hffff, 16'h0000);
    load_lobe(8'd2, 16'sd32767, 16'sd32767, 16'sd32767, 16'hffff, 16'hffff, 16'hffff);
    load_lobe(8'd3, 16'sd0, 16'sd16384, 16'sd0, 16'h1234, 16'h8000, 16'h0001);
    load_lobe(8'd255, 16'sd0, 16'sd0, 16'sd16384, 16'hffff, 16'hffff, 16'hffff);
    query_dir(16'sd16384, 16'sd0, 16'sd0);
    query_dir(-16'sd32768, -16'sd32768, -16'sd32768);
    query_dir(16'sd32767, 16'sd32767, 16'sd32767);
    query_dir(16'sd0, 16'sd0, 16'sd0);
    query_dir(16'sd200, -16'sd100, 16'sd50);
    wait_drained();
    write_reg(CFG_SHARPNESS, 9'd0);
    query_dir(16'sd16384, 16'sd0, 16'sd0);
    wait_drained();
    write_reg(CFG_SHARPNESS, 9'd127);
    query_dir(16'sd0, 16'sd16384, 16'sd0);
    query_dir(16'sd30, 16'sd20, -16'sd10);
    wait_drained();
    write_reg(CFG_NUM_LOBES, 9'd1);
    write_reg(CFG_SHARPNESS, 9'd1);
    query_dir(16'sd0, 16'sd0, 16'sd16384);
    wait_drained();
    write_reg(CFG_NUM_LOBES, 9'd0);
    query_dir(16'sd16384, 16'sd16384, 16'sd0);
    wait_drained();

    // fill the whole table so any lobe count is legal from here on
    for (int i = 0; i < 256; i++)
      load_lobe(i[7:0], rand_comp(), rand_comp(), rand_comp(),
                16'($urandom), 16'($urandom), 16'($urandom));

    for (int ph = 0; ph < 11; ph++) begin
      wait_drained();
      case (ph)
        2: cnt = 9'd256;
        5: cnt = 9'd511;
        default: cnt = 9'($urandom_range(1, 16));
      endcase
      write_reg(CFG_NUM_LOBES, cnt);
      case ($urandom_range(0, 3))
        0: write_reg(CFG_SHARPNESS, 9'd0);
        1: write_reg(CFG_SHARPNESS, 9'd127);
        default: write_reg(CFG_SHARPNESS, 9'($urandom_range(1, 127)));
      endcase
      gaps_on = (ph % 4 != 3);
      if (ph == 7) hold_go = 1;
      for (int k = 0; k < ((cnt > 16) ? 12 : 40); k++) begin
        if ($urandom_range(0, 9) < 6) query_dir(rand_comp(), rand_comp(), rand_comp());
        else load_lobe(8'($urandom), rand_comp(), rand_comp(), rand_comp(),
                       16'($urandom), 16'($urandom), 16'($urandom));
      end
      if (ph == 4) begin
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end

    wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
